// ----- sv/rtn_pkg.sv -----
// Shared types, widths and helper functions of the ray/triangle nearest-hit unit.
// Used by rtn_geom, rtn_div and ray_triangle_nearest_hit; depends on nothing else.
package rtn_pkg;

  localparam int COORD_BITS = 21;
  localparam int VEC_BITS   = 3 * COORD_BITS;
  localparam int EDGE_W     = COORD_BITS + 1;
  localparam int CROSS_W    = 2 * EDGE_W + 1;
  localparam int PROD_W     = EDGE_W + CROSS_W;
  localparam int DOT_W      = PROD_W + 2;
  localparam int DIST_BITS  = 32;
  localparam int DIST_FRAC  = 16;
  localparam int DET_EPS_W  = 32;
  localparam int T_EPS_W    = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int GEOM_STAGES = 5;
  localparam int LATENCY    = GEOM_STAGES + DIST_BITS + 1;

  localparam logic [DET_EPS_W-1:0] DET_EPS_RESET = DET_EPS_W'(6871948);
  localparam logic [T_EPS_W-1:0]   T_EPS_RESET   = T_EPS_W'(7);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DET_EPS = 2'd0,
    REG_T_EPS   = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [EDGE_W-1:0] x;
    logic signed [EDGE_W-1:0] y;
    logic signed [EDGE_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [CROSS_W-1:0] x;
    logic signed [CROSS_W-1:0] y;
    logic signed [CROSS_W-1:0] z;
  } cross_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] x;
    logic signed [PROD_W-1:0] y;
    logic signed [PROD_W-1:0] z;
  } prod3_t;

  // Everything the divider pipeline needs for one word.
  typedef struct packed {
    logic                 ok;
    logic                 sat;
    logic [DIST_BITS-1:0] nearest;
    logic [DOT_W-1:0]     det;
    logic [DOT_W:0]       rem;
    logic [DIST_FRAC-1:0] lo;
  } div_in_t;

  typedef struct packed {
    logic                 ok;
    logic                 sat;
    logic [DIST_BITS-1:0] nearest;
    logic [DIST_BITS-1:0] quo;
  } div_out_t;

  function automatic vec_t unpack(logic [VEC_BITS-1:0] p);
    logic signed [COORD_BITS-1:0] cx, cy, cz;
    vec_t v;
    cx = p[0 +: COORD_BITS];
    cy = p[COORD_BITS +: COORD_BITS];
    cz = p[2*COORD_BITS +: COORD_BITS];
    v.x = EDGE_W'(cx);
    v.y = EDGE_W'(cy);
    v.z = EDGE_W'(cz);
    return v;
  endfunction

  function automatic vec_t vsub(vec_t a, vec_t b);
    vec_t r;
    r.x = a.x - b.x;
    r.y = a.y - b.y;
    r.z = a.z - b.z;
    return r;
  endfunction

  function automatic logic signed [CROSS_W-1:0] cterm(
      logic signed [EDGE_W-1:0] a0, logic signed [EDGE_W-1:0] b0,
      logic signed [EDGE_W-1:0] a1, logic signed [EDGE_W-1:0] b1);
    logic signed [2*EDGE_W-1:0] m0, m1;
    m0 = a0 * b0;
    m1 = a1 * b1;
    return CROSS_W'(m0) - CROSS_W'(m1);
  endfunction

  function automatic cross_t vcross(vec_t a, vec_t b);
    cross_t r;
    r.x = cterm(a.y, b.z, a.z, b.y);
    r.y = cterm(a.z, b.x, a.x, b.z);
    r.z = cterm(a.x, b.y, a.y, b.x);
    return r;
  endfunction

  function automatic logic signed [PROD_W-1:0] pmul(
      logic signed [EDGE_W-1:0] a, logic signed [CROSS_W-1:0] b);
    logic signed [PROD_W-1:0] m;
    m = a * b;
    return m;
  endfunction

  function automatic prod3_t dotp(vec_t a, cross_t b);
    prod3_t r;
    r.x = pmul(a.x, b.x);
    r.y = pmul(a.y, b.y);
    r.z = pmul(a.z, b.z);
    return r;
  endfunction

  function automatic logic signed [DOT_W-1:0] sum3(prod3_t p);
    logic signed [PROD_W-1:0] px, py, pz;
    px = p.x;
    py = p.y;
    pz = p.z;
    return DOT_W'(px) + DOT_W'(py) + DOT_W'(pz);
  endfunction

endpackage

// ----- sv/rtn_geom.sv -----
// Geometry pipeline: edges, cross products, dot products, sign fix and the
// inside-triangle tests, five register stages. Depends on rtn_pkg.
module rtn_geom (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic [rtn_pkg::VEC_BITS-1:0]        ray_origin_i,
  input  logic [rtn_pkg::VEC_BITS-1:0]        ray_dir_i,
  input  logic [rtn_pkg::DIST_BITS-1:0]       nearest_in_i,
  input  logic [rtn_pkg::VEC_BITS-1:0]        vert_a_i,
  input  logic [rtn_pkg::VEC_BITS-1:0]        vert_b_i,
  input  logic [rtn_pkg::VEC_BITS-1:0]        vert_c_i,
  input  logic [rtn_pkg::DET_EPS_W-1:0]       det_eps_i,
  output logic                                valid_o,
  output rtn_pkg::div_in_t                    data_o
);

  localparam int DW = rtn_pkg::DOT_W;

  logic valid_a_q, valid_b_q, valid_c_q, valid_d_q, valid_e_q;

  rtn_pkg::vec_t   e1_a_q, e2_a_q, s_a_q, d_a_q;
  rtn_pkg::vec_t   e1_b_q, e2_b_q, s_b_q, d_b_q;
  rtn_pkg::cross_t h_b_q, q_b_q;
  rtn_pkg::prod3_t det_p_q, un_p_q, vn_p_q, tn_p_q;
  logic signed [DW-1:0] det_d, un_d, vn_d, tn_d;
  logic signed [DW-1:0] det_q, un_q, vn_q, tn_q;
  logic [rtn_pkg::DIST_BITS-1:0] near_a_q, near_b_q, near_c_q, near_d_q;
  rtn_pkg::div_in_t data_d, data_q;

  rtn_pkg::vec_t va, vb, vc, org, dir;
  logic signed [DW:0]   du_diff;
  logic signed [DW+1:0] duv_diff;
  logic                 sign_neg;

  always_comb begin
    va  = rtn_pkg::unpack(vert_a_i);
    vb  = rtn_pkg::unpack(vert_b_i);
    vc  = rtn_pkg::unpack(vert_c_i);
    org = rtn_pkg::unpack(ray_origin_i);
    dir = rtn_pkg::unpack(ray_dir_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
      valid_d_q <= 1'b0;
      valid_e_q <= 1'b0;
    end else begin
      valid_a_q <= in_valid_i;
      valid_b_q <= valid_a_q;
      valid_c_q <= valid_b_q;
      valid_d_q <= valid_c_q;
      valid_e_q <= valid_d_q;
    end
  end

  // Sums of the three products; a negative determinant flips all four.
  always_comb begin
    det_d    = rtn_pkg::sum3(det_p_q);
    un_d     = rtn_pkg::sum3(un_p_q);
    vn_d     = rtn_pkg::sum3(vn_p_q);
    tn_d     = rtn_pkg::sum3(tn_p_q);
    sign_neg = det_d[DW-1];
    if (sign_neg) begin
      det_d = -det_d;
      un_d  = -un_d;
      vn_d  = -vn_d;
      tn_d  = -tn_d;
    end
  end

  always_comb begin
    du_diff  = (DW+1)'(det_q) - (DW+1)'(un_q);
    duv_diff = (DW+2)'(det_q) - (DW+2)'(un_q) - (DW+2)'(vn_q);
    data_d.ok = (det_q != '0)
             && ($unsigned(det_q) >= DW'(det_eps_i))
             && !un_q[DW-1] && !du_diff[DW]
             && !vn_q[DW-1] && !duv_diff[DW+1]
             && !tn_q[DW-1] && (tn_q != '0);
    // The quotient needs more than DIST_BITS bits when tn >= det * 2^DIST_FRAC.
    data_d.sat = ({{rtn_pkg::DIST_FRAC{1'b0}}, $unsigned(tn_q)} >=
                  {$unsigned(det_q), {rtn_pkg::DIST_FRAC{1'b0}}});
    data_d.nearest = near_d_q;
    data_d.det     = $unsigned(det_q);
    data_d.rem     = (DW+1)'($unsigned(tn_q) >> rtn_pkg::DIST_FRAC);
    data_d.lo      = tn_q[rtn_pkg::DIST_FRAC-1:0];
  end

  always_ff @(posedge clk_i) begin
    e1_a_q   <= rtn_pkg::vsub(vb, va);
    e2_a_q   <= rtn_pkg::vsub(vc, va);
    s_a_q    <= rtn_pkg::vsub(org, va);
    d_a_q    <= dir;
    near_a_q <= nearest_in_i;

    h_b_q    <= rtn_pkg::vcross(d_a_q, e2_a_q);
    q_b_q    <= rtn_pkg::vcross(s_a_q, e1_a_q);
    e1_b_q   <= e1_a_q;
    e2_b_q   <= e2_a_q;
    s_b_q    <= s_a_q;
    d_b_q    <= d_a_q;
    near_b_q <= near_a_q;

    det_p_q  <= rtn_pkg::dotp(e1_b_q, h_b_q);
    un_p_q   <= rtn_pkg::dotp(s_b_q, h_b_q);
    vn_p_q   <= rtn_pkg::dotp(d_b_q, q_b_q);
    tn_p_q   <= rtn_pkg::dotp(e2_b_q, q_b_q);
    near_c_q <= near_b_q;

    det_q    <= det_d;
    un_q     <= un_d;
    vn_q     <= vn_d;
    tn_q     <= tn_d;
    near_d_q <= near_c_q;

    data_q   <= data_d;
  end

  assign valid_o = valid_e_q;
  assign data_o  = data_q;

endmodule

// ----- sv/rtn_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage, giving
// floor(tn * 2^DIST_FRAC / det). Depends on rtn_pkg.
module rtn_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  rtn_pkg::div_in_t   data_i,
  output logic               valid_o,
  output rtn_pkg::div_out_t  data_o
);

  localparam int NS = rtn_pkg::DIST_BITS;
  localparam int DW = rtn_pkg::DOT_W;

  logic                 valid_q [0:NS];
  rtn_pkg::div_in_t     st_q    [0:NS];
  logic [NS-1:0]        quo_q   [0:NS];

  always_comb begin
    valid_q[0] = valid_i;
    st_q[0]    = data_i;
    quo_q[0]   = '0;
  end

  for (genvar k = 0; k < NS; k++) begin : g_step
    logic [DW:0]      shifted;
    logic             take;
    rtn_pkg::div_in_t st_d;

    always_comb begin
      // The remainder stays below det, so the shift never drops a set bit.
      shifted = {st_q[k].rem[DW-1:0], st_q[k].lo[rtn_pkg::DIST_FRAC-1]};
      take    = shifted >= {1'b0, st_q[k].det};
      st_d     = st_q[k];
      st_d.rem = take ? shifted - {1'b0, st_q[k].det} : shifted;
      st_d.lo  = {st_q[k].lo[rtn_pkg::DIST_FRAC-2:0], 1'b0};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k+1] <= 1'b0;
      end else begin
        valid_q[k+1] <= valid_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[k+1]  <= st_d;
      quo_q[k+1] <= {quo_q[k][NS-2:0], take};
    end
  end

  assign valid_o        = valid_q[NS];
  assign data_o.ok      = st_q[NS].ok;
  assign data_o.sat     = st_q[NS].sat;
  assign data_o.nearest = st_q[NS].nearest;
  assign data_o.quo     = quo_q[NS];

endmodule

// ----- sv/ray_triangle_nearest_hit.sv -----
// Top level of the ray/triangle nearest-hit unit: configuration registers,
// geometry pipeline, divider pipeline and result register. Depends on rtn_pkg.
//
// The unit takes one ray/triangle word per clock (start while busy is low;
// busy is high only in the cycle after reset) and returns each result as a
// one-cycle done_o pulse that cannot be held off. Five stages do the edges,
// cross and dot products and the inside tests; the 32-stage divider, one
// quotient bit per stage, sets most of the latency.
module ray_triangle_nearest_hit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [rtn_pkg::VEC_BITS-1:0]          ray_origin_i,
  input  logic [rtn_pkg::VEC_BITS-1:0]          ray_dir_i,
  input  logic [rtn_pkg::DIST_BITS-1:0]         nearest_in_i,
  input  logic [rtn_pkg::VEC_BITS-1:0]          vert_a_i,
  input  logic [rtn_pkg::VEC_BITS-1:0]          vert_b_i,
  input  logic [rtn_pkg::VEC_BITS-1:0]          vert_c_i,
  output logic                                  done_o,
  output logic [rtn_pkg::DIST_BITS-1:0]         nearest_out_o,
  output logic                                  closer_hit_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [rtn_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [rtn_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  logic                             busy_q;
  logic [rtn_pkg::DET_EPS_W-1:0]    det_eps_q;
  logic [rtn_pkg::T_EPS_W-1:0]      t_eps_q;
  logic                             accept;
  logic                             geo_valid, div_valid;
  rtn_pkg::div_in_t                 geo_data;
  rtn_pkg::div_out_t                div_data;
  logic [rtn_pkg::DIST_BITS-1:0]    t_val;
  logic                             hit;
  logic                             done_q, closer_q;
  logic [rtn_pkg::DIST_BITS-1:0]    nearest_q;

  assign busy        = busy_q;
  assign accept      = start && !busy_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      det_eps_q <= rtn_pkg::DET_EPS_RESET;
      t_eps_q   <= rtn_pkg::T_EPS_RESET;
    end else begin
      busy_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        case (rtn_pkg::cfg_reg_e'(cfg_index_i))
          rtn_pkg::REG_DET_EPS: det_eps_q <= cfg_data_i[rtn_pkg::DET_EPS_W-1:0];
          rtn_pkg::REG_T_EPS:   t_eps_q   <= cfg_data_i[rtn_pkg::T_EPS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  rtn_geom u_geom (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (accept),
    .ray_origin_i (ray_origin_i),
    .ray_dir_i    (ray_dir_i),
    .nearest_in_i (nearest_in_i),
    .vert_a_i     (vert_a_i),
    .vert_b_i     (vert_b_i),
    .vert_c_i     (vert_c_i),
    .det_eps_i    (det_eps_q),
    .valid_o      (geo_valid),
    .data_o       (geo_data)
  );

  rtn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (geo_valid),
    .data_i  (geo_data),
    .valid_o (div_valid),
    .data_o  (div_data)
  );

  // A saturated distance equals the no-hit code and so never wins.
  always_comb begin
    t_val = div_data.sat ? '1 : div_data.quo;
    hit   = div_data.ok && (t_val > rtn_pkg::DIST_BITS'(t_eps_q))
         && (t_val < div_data.nearest);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    nearest_q <= hit ? t_val : div_data.nearest;
    closer_q  <= hit;
  end

  assign done_o        = done_q;
  assign nearest_out_o = nearest_q;
  assign closer_hit_o  = closer_q;

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(accept, rtn_pkg::LATENCY))
    else $error("result strobe does not follow an accepted word");

  a_closer_lowers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && closer_hit_o |-> nearest_out_o != '1)
    else $error("closer hit reported with the no-hit distance");

  a_epsilon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit |-> t_val > rtn_pkg::DIST_BITS'(t_eps_q) && div_data.ok)
    else $error("hit taken below the distance threshold");
`endif

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for ray_triangle_nearest_hit: directed and random ray/triangle
// words against an exact fixed-point Moller-Trumbore predictor. Depends on rtn_pkg.
`timescale 1ns / 1ps

module tb;

  localparam logic [rtn_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int Q = 4096;

  typedef logic signed [127:0] wide_t;
  typedef struct {
    logic [rtn_pkg::DIST_BITS-1:0] dist_val;
    logic                          closer;
  } hit_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [rtn_pkg::VEC_BITS-1:0] ray_origin_i = '0, ray_dir_i = '0;
  logic [rtn_pkg::VEC_BITS-1:0] vert_a_i = '0, vert_b_i = '0, vert_c_i = '0;
  logic [rtn_pkg::DIST_BITS-1:0] nearest_in_i = '0;
  logic done_o;
  logic [rtn_pkg::DIST_BITS-1:0] nearest_out_o;
  logic closer_hit_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [rtn_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [rtn_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  logic [rtn_pkg::DET_EPS_W-1:0] det_eps_q = rtn_pkg::DET_EPS_RESET;
  logic [rtn_pkg::T_EPS_W-1:0] t_eps_q = rtn_pkg::T_EPS_RESET;
  hit_t hit_q[$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;

  ray_triangle_nearest_hit dut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic longint coord(logic [rtn_pkg::VEC_BITS-1:0] p, int k);
    return longint'($signed(p[k*rtn_pkg::COORD_BITS +: rtn_pkg::COORD_BITS]));
  endfunction

  function automatic logic [rtn_pkg::VEC_BITS-1:0] pack3(longint x, longint y, longint z);
    logic [63:0] ux, uy, uz;
    ux = x;
    uy = y;
    uz = z;
    return {uz[rtn_pkg::COORD_BITS-1:0], uy[rtn_pkg::COORD_BITS-1:0],
            ux[rtn_pkg::COORD_BITS-1:0]};
  endfunction

  function automatic wide_t dot3(longint ax, longint ay, longint az,
                                 longint bx, longint by, longint bz);
    return wide_t'(ax) * wide_t'(bx) + wide_t'(ay) * wide_t'(by) + wide_t'(az) * wide_t'(bz);
  endfunction

  // Exact intersection test; returns the updated nearest distance and the closer flag.
  function automatic hit_t predict_hit(logic [rtn_pkg::VEC_BITS-1:0] org, dir, va, vb, vc,
                                       logic [rtn_pkg::DIST_BITS-1:0] nearest);
    longint o[3], d[3], a[3], b[3], c[3], e1[3], e2[3], s[3], h[3], qv[3];
    wide_t det, un, vn, tn;
    logic [127:0] quo;
    logic [rtn_pkg::DIST_BITS-1:0] t;
    hit_t r;
    for (int k = 0; k < 3; k++) begin
      o[k] = coord(org, k);
      d[k] = coord(dir, k);
      a[k] = coord(va, k);
      b[k] = coord(vb, k);
      c[k] = coord(vc, k);
      e1[k] = b[k] - a[k];
      e2[k] = c[k] - a[k];
      s[k] = o[k] - a[k];
    end
    h[0] = d[1] * e2[2] - d[2] * e2[1];
    h[1] = d[2] * e2[0] - d[0] * e2[2];
    h[2] = d[0] * e2[1] - d[1] * e2[0];
    qv[0] = s[1] * e1[2] - s[2] * e1[1];
    qv[1] = s[2] * e1[0] - s[0] * e1[2];
    qv[2] = s[0] * e1[1] - s[1] * e1[0];
    det = dot3(e1[0], e1[1], e1[2], h[0], h[1], h[2]);
    un = dot3(s[0], s[1], s[2], h[0], h[1], h[2]);
    vn = dot3(d[0], d[1], d[2], qv[0], qv[1], qv[2]);
    tn = dot3(e2[0], e2[1], e2[2], qv[0], qv[1], qv[2]);
    if (det < 0) begin
      det = -det;
      un = -un;
      vn = -vn;
      tn = -tn;
    end
    r.dist_val = nearest;
    r.closer = 1'b0;
    if (det != 0 && det >= wide_t'({1'b0, det_eps_q}) && un >= 0 && det - un >= 0 &&
        vn >= 0 && det - un - vn >= 0 && tn > 0) begin
      quo = unsigned'(tn <<< rtn_pkg::DIST_FRAC) / unsigned'(det);
      t = (quo > 128'hFFFF_FFFF) ? '1 : quo[rtn_pkg::DIST_BITS-1:0];
      if (t > rtn_pkg::DIST_BITS'(t_eps_q) && t < nearest) begin
        r.dist_val = t;
        r.closer = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (hit_q.size() == 0) begin
        report_mismatch("unexpected result word", 64'(nearest_out_o), 64'd0);
      end else begin
        hit_t want;
        want = hit_q.pop_front();
        if (nearest_out_o !== want.dist_val)
          report_mismatch("nearest_out", 64'(nearest_out_o), 64'(want.dist_val));
        if (closer_hit_o !== want.closer)
          report_mismatch("closer_hit", 64'(closer_hit_o), 64'(want.closer));
      end
    end
  end

  // Leaves start high so back-to-back words need no extra assignment.
  task automatic send_test(logic [rtn_pkg::VEC_BITS-1:0] org, dir, va, vb, vc,
                           logic [rtn_pkg::DIST_BITS-1:0] nearest);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    start <= 1'b1;
    ray_origin_i <= org;
    ray_dir_i <= dir;
    vert_a_i <= va;
    vert_b_i <= vb;
    vert_c_i <= vc;
    nearest_in_i <= nearest;
    do @(posedge clk_i); while (busy);
    hit_q.push_back(predict_hit(org, dir, va, vb, vc, nearest));
  endtask

  task automatic drain;
    start <= 1'b0;
    while (hit_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Leaves cfg_valid_i high; the caller drops it after its last write.
  task automatic write_reg(logic [rtn_pkg::CFG_IDX_W-1:0] idx,
                           logic [rtn_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == rtn_pkg::REG_DET_EPS) det_eps_q = data;
    else if (idx == rtn_pkg::REG_T_EPS) t_eps_q = data[rtn_pkg::T_EPS_W-1:0];
  endtask

  task automatic test_directed;
    logic [rtn_pkg::VEC_BITS-1:0] va, vb, vc, org, dz;
    va = pack3(-Q, -Q, 5 * Q);
    vb = pack3(Q, -Q, 5 * Q);
    vc = pack3(0, Q, 5 * Q);
    org = pack3(0, 0, 0);
    dz = pack3(0, 0, Q);
    send_test(org, dz, va, vb, vc, '1);             // plain hit at t = 5
    send_test(org, dz, va, vc, vb, '1);             // negative determinant
    send_test(org, dz, va, vb, vc, 32'h0005_0000);  // tie with incoming nearest
    send_test(org, dz, va, vb, vc, 32'h0004_0000);  // farther than nearest
    send_test(org, dz, va, vb, vc, 32'h0006_0000);  // closer than nearest
    send_test(org, pack3(0, 0, -Q), va, vb, vc, '1);  // triangle behind the ray
    send_test(org, pack3(0, 0, 1), va, vb, vc, '1);   // large t, still below saturation
    send_test(pack3(3 * Q, 0, 0), dz, va, vb, vc, '1); // u out of range
    send_test(pack3(0, -2 * Q, 0), dz, va, vb, vc, '1); // v below zero
    send_test(pack3(-Q, -Q, 0), dz, va, vb, vc, '1);  // exactly on a vertex
    send_test(org, dz, va, va, vc, '1);               // zero determinant
    send_test('0, '0, '0, '0, '0, '0);
    send_test('1, '1, '1, '1, '1, '1);
    send_test({3{21'h100000}}, {3{21'h0FFFFF}}, {3{21'h100000}}, {3{21'h0FFFFF}},
              {3{21'h155555}}, 32'h8000_0000);
    send_test(org, pack3(0, 0, Q), pack3(-Q, -Q, 1), pack3(Q, -Q, 1), pack3(0, Q, 1), '1);
  endtask

  function automatic longint rcoord(int lim);
    return longint'($urandom_range(2 * lim)) - lim;
  endfunction

  task automatic test_random(int n, int pct, bit pause_midway);
    longint a[3], b[3], c[3], o[3], d[3];
    int u, v, kind;
    logic [rtn_pkg::DIST_BITS-1:0] nearest;
    idle_pct = pct;
    for (int i = 0; i < n; i++) begin
      if (pause_midway && i == n / 2) drain();
      kind = $urandom_range(9);
      u = $urandom_range(16);
      v = $urandom_range(16 - u);
      for (int k = 0; k < 3; k++) begin
        a[k] = rcoord(1 << 17);
        b[k] = rcoord(1 << 17);
        c[k] = rcoord(1 << 17);
        o[k] = rcoord(1 << 17);
        d[k] = a[k] + ((b[k] - a[k]) * u + (c[k] - a[k]) * v) / 16 - o[k];
        if (kind == 7) d[k] = -d[k];
      end
      case ($urandom_range(3))
        0: nearest = '1;
        1: nearest = $urandom;
        2: nearest = $urandom_range(32'h0004_0000);
        default: nearest = $urandom_range(32'h0100_0000);
      endcase
      if (kind >= 8)
        send_test(rtn_pkg::VEC_BITS'({$urandom, $urandom}),
                  rtn_pkg::VEC_BITS'({$urandom, $urandom}),
                  rtn_pkg::VEC_BITS'({$urandom, $urandom}),
                  rtn_pkg::VEC_BITS'({$urandom, $urandom}),
                  rtn_pkg::VEC_BITS'({$urandom, $urandom}), $urandom);
      else
        send_test(pack3(o[0], o[1], o[2]), pack3(d[0], d[1], d[2]),
                  pack3(a[0], a[1], a[2]), pack3(b[0], b[1], b[2]),
                  pack3(c[0], c[1], c[2]), nearest);
    end
  endtask

  task automatic test_config(logic [rtn_pkg::DET_EPS_W-1:0] det_eps,
                             logic [rtn_pkg::T_EPS_W-1:0] t_eps);
    drain();
    write_reg(rtn_pkg::REG_DET_EPS, det_eps);
    write_reg(rtn_pkg::REG_T_EPS, {16'hA5A5, t_eps});
    write_reg(REG_UNUSED, $urandom);  // must be ignored
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(450, 15, 1'b1);
    test_config('0, '0);
    test_directed();
    test_random(450, 50, 1'b0);
    test_config('1, '1);
    test_random(60, 0, 1'b0);
    test_config(32'd5000, 16'd4096);
    test_random(420, 0, 1'b0);
    drain();
    repeat (rtn_pkg::LATENCY + 5) @(posedge clk_i);
    if (errors == 0 && hit_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/rtn_pkg.sv
sv/rtn_geom.sv
sv/rtn_div.sv
sv/ray_triangle_nearest_hit.sv
tb/tb.sv
